// ===== rtl/slr_pkg.sv =====
// Shared opcodes and divider status type for the line rasterizer.
`default_nettype none
package slr_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/slr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module slr_div
  import slr_pkg::*;
#(
  parameter int DEN_W = 10,
  parameter int QW    = 18
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DEN_W+QW-1:0]   dividend,
  input  wire logic [DEN_W-1:0]      divisor,
  output logic      [QW-1:0]         quotient,
  output div_stat_t                  stat
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QW-1:0]    sh_r, sh_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Dividend bits shift out of the top of sh_r as quotient bits shift in.
  assign trial = {rem_r, sh_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    if (start) begin
      // upper part is below the divisor since the quotient fits QW bits
      rem_nxt  = dividend[DEN_W+QW-1:QW];
      sh_nxt   = dividend[QW-1:0];
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
  end

  assign quotient  = sh_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== rtl/slope_line_rasterizer.sv =====
// Top level: line state, step sequencing and result register.
`default_nettype none
// A start transaction (opcode 0) latches two endpoints and produces nothing; it
// leaves input stall low. Each step transaction (opcode 1) yields the next
// point of the line, both ends included, with last_point set on the end point,
// after which the block is idle until the next start. A step passes through the
// divide and push states: the minor offset |d_minor|*k/|d_major| comes from a
// radix-2 divider that yields one quotient bit per cycle, and the product
// |d_minor|*k is kept as a running sum. Input stall is high while a step is in
// work; a finished point waits in the output register while the next
// transaction is taken. A step with no line active is accepted and gives no
// point.
module slope_line_rasterizer
  import slr_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_opcode,
  input  wire logic [COORD_BITS-1:0]           in_x_start,
  input  wire logic [COORD_BITS-1:0]           in_y_start,
  input  wire logic [COORD_BITS-1:0]           in_x_end,
  input  wire logic [COORD_BITS-1:0]           in_y_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [COORD_BITS+FRAC_BITS-1:0]      out_point_x,
  output logic [COORD_BITS+FRAC_BITS-1:0]      out_point_y,
  output logic                                 out_last_point
);

  localparam int CB  = COORD_BITS;
  localparam int OW  = COORD_BITS + FRAC_BITS;
  localparam int DVW = CB + OW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CB-1:0]   major_begin_r, major_begin_nxt;
  logic [CB-1:0]   minor_begin_r, minor_begin_nxt;
  logic            major_neg_r, major_neg_nxt;
  logic            minor_neg_r, minor_neg_nxt;
  logic [CB-1:0]   span_r, span_nxt;
  logic [CB-1:0]   mag_minor_r, mag_minor_nxt;
  logic            x_major_r, x_major_nxt;
  logic [CB-1:0]   step_r, step_nxt;
  logic [2*CB-1:0] acc_r, acc_nxt;
  logic [OW-1:0]   px_r, px_nxt;
  logic [OW-1:0]   py_r, py_nxt;
  logic            last_r, last_nxt;

  logic          in_acc;
  logic          div_start;
  logic [DVW-1:0] dividend;
  logic [OW-1:0] quot;
  div_stat_t     dstat;

  logic [CB:0]   dx, dy;
  logic [CB-1:0] adx, ady;
  logic          x_major_new;
  logic [OW-1:0] q_eff;
  logic [CB-1:0] major_pt;
  logic [OW-1:0] pmaj, pmin, minor_base;
  logic          is_last;
  logic          out_free;

  assign in_acc = in_valid && !in_stall;

  assign dx  = {1'b0, in_x_end} - {1'b0, in_x_start};
  assign dy  = {1'b0, in_y_end} - {1'b0, in_y_start};
  assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  assign x_major_new = (ady < adx);

  assign div_start = in_acc && (in_opcode == OP_STEP) && active_r;
  assign dividend  = DVW'(acc_r) << FRAC_BITS;

  slr_div #(
    .DEN_W(CB),
    .QW   (OW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dividend),
    .divisor (span_r),
    .quotient(quot),
    .stat    (dstat)
  );

  // equal endpoints: span is zero and the offset is zero
  assign q_eff      = (span_r == '0) ? '0 : quot;
  assign major_pt   = major_neg_r ? (major_begin_r - step_r) : (major_begin_r + step_r);
  assign pmaj       = OW'(major_pt) << FRAC_BITS;
  assign minor_base = OW'(minor_begin_r) << FRAC_BITS;
  assign pmin       = minor_neg_r ? (minor_base - q_eff) : (minor_base + q_eff);
  assign is_last    = (step_r >= span_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    out_valid_nxt   = out_valid_r && out_stall;
    major_begin_nxt = major_begin_r;
    minor_begin_nxt = minor_begin_r;
    major_neg_nxt   = major_neg_r;
    minor_neg_nxt   = minor_neg_r;
    span_nxt        = span_r;
    mag_minor_nxt   = mag_minor_r;
    x_major_nxt     = x_major_r;
    step_nxt        = step_r;
    acc_nxt         = acc_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    last_nxt        = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_START) begin
            x_major_nxt = x_major_new;
            if (x_major_new) begin
              major_begin_nxt = in_x_start;
              minor_begin_nxt = in_y_start;
              major_neg_nxt   = dx[CB];
              minor_neg_nxt   = dy[CB];
              span_nxt        = adx;
              mag_minor_nxt   = ady;
            end else begin
              major_begin_nxt = in_y_start;
              minor_begin_nxt = in_x_start;
              major_neg_nxt   = dy[CB];
              minor_neg_nxt   = dx[CB];
              span_nxt        = ady;
              mag_minor_nxt   = adx;
            end
            step_nxt   = '0;
            acc_nxt    = '0;
            active_nxt = 1'b1;
          end else if (active_r) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (dstat.done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          px_nxt        = x_major_r ? pmaj : pmin;
          py_nxt        = x_major_r ? pmin : pmaj;
          last_nxt      = is_last;
          if (is_last) begin
            active_nxt = 1'b0;
          end else begin
            step_nxt = step_r + CB'(1);
            acc_nxt  = acc_r + (2*CB)'(mag_minor_r);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_begin_r <= major_begin_nxt;
    minor_begin_r <= minor_begin_nxt;
    major_neg_r   <= major_neg_nxt;
    minor_neg_r   <= minor_neg_nxt;
    span_r        <= span_nxt;
    mag_minor_r   <= mag_minor_nxt;
    x_major_r     <= x_major_nxt;
    step_r        <= step_nxt;
    acc_r         <= acc_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    last_r        <= last_nxt;
  end

  // divider busy flag is folded into the state; it only drives stall here
  assign in_stall       = (state_r != ST_IDLE) || dstat.busy;
  assign out_valid      = out_valid_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_last_point = last_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for slope_line_rasterizer: predicted points vs. DUT output.
`default_nettype none
module testbench;
  import slr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS     = 10;
  localparam int FRAC_BITS      = 8;
  localparam int POINT_BITS     = COORD_BITS + FRAC_BITS;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 100;

  typedef struct packed {
    logic [POINT_BITS-1:0] px;
    logic [POINT_BITS-1:0] py;
    logic                  last;
  } point_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  in_opcode  = OP_START;
  logic [COORD_BITS-1:0] in_x_start = '0;
  logic [COORD_BITS-1:0] in_y_start = '0;
  logic [COORD_BITS-1:0] in_x_end   = '0;
  logic [COORD_BITS-1:0] in_y_end   = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [POINT_BITS-1:0] out_point_x;
  logic [POINT_BITS-1:0] out_point_y;
  logic                  out_last_point;

  slope_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_last_point(out_last_point)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Line state mirrored from the block
  logic [COORD_BITS-1:0]        major_begin;
  logic [COORD_BITS-1:0]        minor_begin;
  logic signed [COORD_BITS:0]   major_delta;
  logic signed [COORD_BITS:0]   minor_delta;
  logic                         x_is_major;
  logic [COORD_BITS:0]          step_count;
  logic                         line_active = 1'b0;

  point_t point_queue[$];
  int     mismatches      = 0;
  logic   idle_on         = 1'b0;
  logic   holdoff_request = 1'b0;
  int     holdoff_left    = 0;
  int     stall_left      = 0;
  int     quiet_cycles    = 0;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Mostly short, a few long
  function automatic int pick_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 9) < 6) return 0;
    return pick_len();
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_end(logic [COORD_BITS-1:0] base, int reach);
    int lo;
    int hi;
    lo = int'(base) - reach;
    hi = int'(base) + reach;
    if (lo < 0) lo = 0;
    if (hi > (1 << COORD_BITS) - 1) hi = (1 << COORD_BITS) - 1;
    return COORD_BITS'($urandom_range(lo, hi));
  endfunction

  // Updates the line state for one accepted transaction and queues the point it yields
  function automatic void rasterize_item(logic op, logic [COORD_BITS-1:0] xs,
                                         logic [COORD_BITS-1:0] ys,
                                         logic [COORD_BITS-1:0] xe,
                                         logic [COORD_BITS-1:0] ye);
    int     dx;
    int     dy;
    int     span;
    int     k;
    int     major;
    longint off;
    longint minor;
    logic [POINT_BITS-1:0] pmaj;
    logic [POINT_BITS-1:0] pmin;
    point_t pt;
    if (op == OP_START) begin
      dx = int'(xe) - int'(xs);
      dy = int'(ye) - int'(ys);
      x_is_major = mag(dy) < mag(dx);
      if (x_is_major) begin
        major_begin = xs;
        minor_begin = ys;
        major_delta = (COORD_BITS+1)'(dx);
        minor_delta = (COORD_BITS+1)'(dy);
      end else begin
        major_begin = ys;
        minor_begin = xs;
        major_delta = (COORD_BITS+1)'(dy);
        minor_delta = (COORD_BITS+1)'(dx);
      end
      step_count  = '0;
      line_active = 1'b1;
      return;
    end
    if (!line_active) return;
    span  = mag(int'(major_delta));
    k     = int'(step_count);
    major = (major_delta < 0) ? int'(major_begin) - k : int'(major_begin) + k;
    off   = 0;
    if (span != 0) begin
      // magnitude divided, sign applied after: truncation toward zero
      off = ((longint'(mag(int'(minor_delta))) * k) << FRAC_BITS) / span;
      if (minor_delta < 0) off = -off;
    end
    minor   = longint'(minor_begin) * (longint'(1) << FRAC_BITS) + off;
    pmaj    = POINT_BITS'(major << FRAC_BITS);
    pmin    = POINT_BITS'(minor);
    pt.px   = x_is_major ? pmaj : pmin;
    pt.py   = x_is_major ? pmin : pmaj;
    pt.last = (k >= span);
    point_queue.push_back(pt);
    if (pt.last) line_active = 1'b0;
    else step_count = step_count + 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [POINT_BITS-1:0] got,
                                 logic [POINT_BITS-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Called at a falling edge; returns at a falling edge after the trailing gap
  task automatic send_item(logic op, logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                           logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye);
    in_valid   = 1'b1;
    in_opcode  = op;
    in_x_start = xs;
    in_y_start = ys;
    in_x_end   = xe;
    in_y_end   = ye;
    do @(posedge clk); while (in_stall);
    rasterize_item(op, xs, ys, xe, ye);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (pick_gap()) @(negedge clk);
  endtask

  // Coordinate fields carry noise on steps
  task automatic send_step();
    send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (point_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_step();                                     // no line yet: nothing comes out
    send_item(OP_START, '0, '0, '1, '1);             // full-scale diagonal, tie goes to y
    repeat (3) send_step();
    send_item(OP_START, '1, '1, '0, '0);             // restart mid-line, reversed
    repeat (2) send_step();
    send_item(OP_START, 10'd5, 10'd7, 10'd5, 10'd7); // single point, then idle step
    repeat (2) send_step();
    send_item(OP_START, 10'd3, 10'd12, 10'd3, 10'd10); // vertical, downward, one extra step
    repeat (4) send_step();
    send_item(OP_START, 10'd10, 10'd4, 10'd12, 10'd4); // horizontal
    repeat (3) send_step();
    send_item(OP_START, 10'd9, 10'd9, 10'd6, 10'd10);  // x major, negative, thirds
    repeat (4) send_step();
  endtask

  // Receiver holds off while steps keep coming, so the input side backs up
  task automatic test_holdoff();
    idle_on         = 1'b0;
    holdoff_request = 1'b1;
    send_item(OP_START, 10'd100, 10'd200, 10'd120, 10'd193);
    repeat (21) send_step();
  endtask

  task automatic test_full_span();
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] b1;
    idle_on = 1'b1;
    a0 = $urandom_range(0, 1) ? '0 : '1;
    b0 = COORD_BITS'($urandom);
    b1 = COORD_BITS'($urandom);
    if ($urandom_range(0, 1)) send_item(OP_START, a0, b0, ~a0, b1);
    else send_item(OP_START, b0, a0, b1, ~a0);
    repeat (1 << COORD_BITS) send_step();
  endtask

  task automatic test_random_lines(int target);
    int counted;
    int reach;
    int pick;
    int npts;
    int steps;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    counted = 0;
    while (counted < target) begin
      idle_on = ($urandom_range(0, 5) != 0);
      pick    = $urandom_range(0, 99);
      reach   = (pick < 85) ? 8 : ((pick < 97) ? 64 : (1 << COORD_BITS) - 1);
      xs      = COORD_BITS'($urandom);
      ys      = COORD_BITS'($urandom);
      xe      = pick_end(xs, reach);
      ye      = pick_end(ys, reach);
      npts    = mag(int'(xe) - int'(xs));
      if (mag(int'(ye) - int'(ys)) > npts) npts = mag(int'(ye) - int'(ys));
      npts++;
      // mostly whole lines; some cut short by a new start, some run past the end
      pick = $urandom_range(0, 99);
      if (pick < 80) steps = npts;
      else if (pick < 90) steps = $urandom_range(0, npts - 1);
      else steps = npts + $urandom_range(1, 3);
      send_item(OP_START, xs, ys, xe, ye);
      counted++;
      for (int i = 0; i < steps; i++) begin
        send_step();
        if (i < npts) counted++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (holdoff_request) begin
      holdoff_left    = HOLDOFF_CYCLES;
      holdoff_request = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_len() - 1;
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_points
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (point_queue.size() == 0) begin
        report_mismatch("point with none pending", out_point_x, '0);
      end else begin
        want = point_queue.pop_front();
        if (out_point_x !== want.px) report_mismatch("point_x", out_point_x, want.px);
        if (out_point_y !== want.py) report_mismatch("point_y", out_point_y, want.py);
        if (out_last_point !== want.last)
          report_mismatch("last_point", POINT_BITS'(out_last_point), POINT_BITS'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL slope_line_rasterizer");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    wait_drain();
    test_holdoff();
    wait_drain();
    test_full_span();
    wait_drain();
    test_random_lines(550);
    wait_drain();
    if (mismatches == 0) begin
      $display("PASS slope_line_rasterizer");
    end else begin
      $display("FAIL slope_line_rasterizer");
    end
    $finish;
  end

endmodule
`default_nettype wire
